/* src/sat_pkg.sv */
package sat_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W       = 32;
  localparam int OFF_W        = ADDR_W + 1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_UNMAPPED = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NODUMP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } walk_state_t;

  typedef struct packed {
    logic              loadable;
    logic              exec;
    logic              write;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mem_size;
    logic [ADDR_W-1:0] file_size;
    logic [ADDR_W-1:0] file_offset;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } tbl_rd_t;

endpackage

/* src/sat_if.sv */
interface sat_req_if;
  logic                        valid;
  logic                        ready;
  sat_pkg::op_t                op;
  logic [sat_pkg::IDX_W-1:0]   entry_index;
  logic                        entry_loadable;
  logic [sat_pkg::ADDR_W-1:0]  entry_base;
  logic [sat_pkg::ADDR_W-1:0]  entry_mem_size;
  logic [sat_pkg::ADDR_W-1:0]  entry_file_size;
  logic [sat_pkg::ADDR_W-1:0]  entry_file_offset;
  logic                        entry_exec;
  logic                        entry_write;
  logic [sat_pkg::ADDR_W-1:0]  address;

  modport source (
    output valid, op, entry_index, entry_loadable, entry_base, entry_mem_size,
           entry_file_size, entry_file_offset, entry_exec, entry_write, address,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, entry_loadable, entry_base, entry_mem_size,
           entry_file_size, entry_file_offset, entry_exec, entry_write, address,
    output ready
  );
endinterface

interface sat_rsp_if;
  logic                       valid;
  logic                       ready;
  sat_pkg::status_t           status;
  logic [sat_pkg::IDX_W-1:0]  segment_index;
  logic [sat_pkg::OFF_W-1:0]  file_offset;
  logic                       executable;
  logic                       writable;

  modport source (
    output valid, status, segment_index, file_offset, executable, writable,
    input  ready
  );
  modport sink (
    input  valid, status, segment_index, file_offset, executable, writable,
    output ready
  );
endinterface

interface sat_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sat_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/segment_address_translator.sv */
// Table write: entry and result word registered at the accepting edge.
// Lookup: entries are read in index order, up to entry_count capped at 16, and
// the first hit or the end of the walk loads the result. One item in flight.
// Reset (rst, synchronous) clears the walker state, the output valid and
// entry_count; table contents stay undefined until written.
module segment_address_translator (
  input  logic      clk,
  input  logic      rst,
  sat_cfg_if.sink   cfg,
  sat_req_if.sink   req,
  sat_rsp_if.source rsp
);
  import sat_pkg::*;

  logic [CNT_W-1:0] entry_count;
  tbl_wr_t          wr;
  tbl_rd_t          rd;
  entry_t           rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid) begin
      entry_count <= cfg.data;
    end
  end

  sat_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  sat_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .req         (req),
    .rsp         (rsp),
    .wr          (wr),
    .rd          (rd),
    .rd_data     (rd_data)
  );

endmodule

/* src/sat_table.sv */
module sat_table (
  input  logic             clk,
  input  sat_pkg::tbl_wr_t wr,
  input  sat_pkg::tbl_rd_t rd,
  output sat_pkg::entry_t  rd_data
);
  import sat_pkg::*;

  entry_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.idx];
    end
  end

endmodule

/* src/sat_walker.sv */
module sat_walker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [sat_pkg::CNT_W-1:0] entry_count,
  sat_req_if.sink                   req,
  sat_rsp_if.source                 rsp,
  output sat_pkg::tbl_wr_t          wr,
  output sat_pkg::tbl_rd_t          rd,
  input  sat_pkg::entry_t           rd_data
);
  import sat_pkg::*;

  walk_state_t       state;
  walk_state_t       state_next;
  logic              accept;
  logic [CNT_W-1:0]  limit;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  lim_q;
  logic [CNT_W-1:0]  issue_idx;
  logic [IDX_W-1:0]  chk_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic [ADDR_W-1:0] hit_diff;
  entry_t            hit_ent;
  logic [ADDR_W-1:0] range_end;
  logic              hit;
  logic              scan_start;
  logic              issue_adv;
  logic              hit_load;
  logic              res_load;
  status_t           res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [OFF_W-1:0]  res_off;
  logic              res_exec;
  logic              res_write;
  logic              out_valid;
  status_t           out_status;
  logic [IDX_W-1:0]  out_idx;
  logic [OFF_W-1:0]  out_off;
  logic              out_exec;
  logic              out_write;

  assign limit     = (entry_count > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : entry_count;
  assign range_end = rd_data.base + rd_data.mem_size;
  assign hit       = rd_data.loadable && (addr_q >= rd_data.base) && (addr_q < range_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = (state == ST_IDLE) && (!out_valid || rsp.ready);
    accept     = req.valid && req.ready;
    wr.en      = 1'b0;
    wr.idx     = req.entry_index;
    wr.data    = '{loadable:    req.entry_loadable,
                   exec:        req.entry_exec,
                   write:       req.entry_write,
                   base:        req.entry_base,
                   mem_size:    req.entry_mem_size,
                   file_size:   req.entry_file_size,
                   file_offset: req.entry_file_offset};
    rd.en      = 1'b0;
    rd.idx     = '0;
    scan_start = 1'b0;
    issue_adv  = 1'b0;
    hit_load   = 1'b0;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_idx    = '0;
    res_off    = '0;
    res_exec   = 1'b0;
    res_write  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.op == OP_WRITE) begin
            wr.en    = ({1'b0, req.entry_index} < CNT_W'(MAX_SEGMENTS));
            res_load = 1'b1;
          end else if (limit == '0) begin
            res_load   = 1'b1;
            res_status = STAT_UNMAPPED;
          end else begin
            rd.en      = 1'b1;
            scan_start = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          hit_load   = 1'b1;
          state_next = ST_DONE;
        end else if (issue_idx == lim_q) begin
          res_load   = 1'b1;
          res_status = STAT_UNMAPPED;
          state_next = ST_IDLE;
        end else begin
          rd.en     = 1'b1;
          rd.idx    = issue_idx[IDX_W-1:0];
          issue_adv = 1'b1;
        end
      end
      ST_DONE: begin
        res_load  = 1'b1;
        res_idx   = hit_idx;
        res_exec  = hit_ent.exec;
        res_write = hit_ent.write;
        if (hit_ent.mem_size == '0) begin
          res_status = STAT_EMPTY;
        end else if (hit_ent.mem_size != hit_ent.file_size) begin
          res_status = STAT_NODUMP;
        end else begin
          res_off = {1'b0, hit_ent.file_offset} + {1'b0, hit_diff};
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      addr_q    <= req.address;
      lim_q     <= limit;
      issue_idx <= CNT_W'(1);
      chk_idx   <= '0;
    end else if (issue_adv) begin
      issue_idx <= issue_idx + CNT_W'(1);
      chk_idx   <= issue_idx[IDX_W-1:0];
    end
    if (hit_load) begin
      hit_idx  <= chk_idx;
      hit_diff <= addr_q - rd_data.base;
      hit_ent  <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_idx    <= res_idx;
      out_off    <= res_off;
      out_exec   <= res_exec;
      out_write  <= res_write;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.segment_index = out_idx;
  assign rsp.file_offset   = out_off;
  assign rsp.executable    = out_exec;
  assign rsp.writable      = out_write;

endmodule

/* tb/sv/segment_address_translator_checker.sv */
module segment_address_translator_checker
  import sat_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sat_cfg_if   cfg,
  sat_req_if   req,
  sat_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   segment_index;
    logic [OFF_W-1:0]   file_offset;
    logic               executable;
    logic               writable;
  } xlat_t;

  logic [ADDR_W-1:0] seg_base      [MAX_SEGMENTS];
  logic [ADDR_W-1:0] seg_mem_size  [MAX_SEGMENTS];
  logic [ADDR_W-1:0] seg_file_size [MAX_SEGMENTS];
  logic [ADDR_W-1:0] seg_file_off  [MAX_SEGMENTS];
  logic              seg_loadable  [MAX_SEGMENTS];
  logic              seg_exec      [MAX_SEGMENTS];
  logic              seg_write     [MAX_SEGMENTS];
  logic [CNT_W-1:0]  search_count;
  xlat_t             xlat_q[$];

  function automatic xlat_t translate(logic [ADDR_W-1:0] addr);
    xlat_t             r;
    int                limit;
    bit                hit;
    logic [ADDR_W-1:0] range_end;
    r = '0;
    r.status = STAT_UNMAPPED;
    limit = (search_count > MAX_SEGMENTS) ? MAX_SEGMENTS : search_count;
    hit = 1'b0;
    for (int i = 0; i < limit; i++) begin
      range_end = seg_base[i] + seg_mem_size[i];
      if (!hit && seg_loadable[i] && addr >= seg_base[i] && addr < range_end) begin
        hit = 1'b1;
        r.segment_index = i[IDX_W-1:0];
        r.executable = seg_exec[i];
        r.writable = seg_write[i];
        if (seg_mem_size[i] == '0) begin
          r.status = STAT_EMPTY;
        end else if (seg_mem_size[i] != seg_file_size[i]) begin
          r.status = STAT_NODUMP;
        end else begin
          r.status = STAT_OK;
          r.file_offset = {1'b0, seg_file_off[i]} + {1'b0, addr - seg_base[i]};
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    xlat_t want;
    if (rst) begin
      search_count = '0;
      xlat_q.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        search_count = cfg.data;
      end
      if (rsp.valid && rsp.ready) begin
        if (xlat_q.size() == 0) begin
          $error("result word with nothing pending");
          errors++;
        end else begin
          want = xlat_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.segment_index !== want.segment_index) begin
            $error("segment_index: expected %0d, actual %0d",
                   want.segment_index, rsp.segment_index);
            errors++;
          end
          if (rsp.file_offset !== want.file_offset) begin
            $error("file_offset: expected %0h, actual %0h",
                   want.file_offset, rsp.file_offset);
            errors++;
          end
          if (rsp.executable !== want.executable) begin
            $error("executable: expected %0d, actual %0d",
                   want.executable, rsp.executable);
            errors++;
          end
          if (rsp.writable !== want.writable) begin
            $error("writable: expected %0d, actual %0d", want.writable, rsp.writable);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_WRITE) begin
          want = '0;
          want.status = STAT_OK;
          seg_base[req.entry_index] = req.entry_base;
          seg_mem_size[req.entry_index] = req.entry_mem_size;
          seg_file_size[req.entry_index] = req.entry_file_size;
          seg_file_off[req.entry_index] = req.entry_file_offset;
          seg_loadable[req.entry_index] = req.entry_loadable;
          seg_exec[req.entry_index] = req.entry_exec;
          seg_write[req.entry_index] = req.entry_write;
        end else begin
          want = translate(req.address);
        end
        xlat_q.push_back(want);
      end
    end
    outstanding = xlat_q.size();
  end

endmodule

/* tb/sv/segment_address_translator_tb.sv */
module segment_address_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  typedef struct {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic              loadable;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mem_size;
    logic [ADDR_W-1:0] file_size;
    logic [ADDR_W-1:0] file_offset;
    logic              exec;
    logic              wr;
    logic [ADDR_W-1:0] address;
  } seg_req_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   in_flight;

  sat_cfg_if cfg_ch ();
  sat_req_if req_ch ();
  sat_rsp_if rsp_ch ();

  segment_address_translator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  segment_address_translator_checker xlat_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (mismatches),
    .outstanding (in_flight)
  );

  logic [ADDR_W-1:0]       aim_base [MAX_SEGMENTS];
  logic [ADDR_W-1:0]       aim_size [MAX_SEGMENTS];
  bit [MAX_SEGMENTS-1:0]   written;
  int                      span;
  int                      gap_pct;
  int                      stall_pct;
  bit                      calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < stall_pct) hold = $urandom_range(1, 16);
      end
    end
  end

  function automatic seg_req_t noise_word();
    seg_req_t w;
    w.op = op_t'($urandom_range(0, 1));
    w.idx = IDX_W'($urandom_range(0, MAX_SEGMENTS - 1));
    w.loadable = 1'($urandom_range(0, 1));
    w.base = $urandom;
    w.mem_size = $urandom;
    w.file_size = $urandom;
    w.file_offset = $urandom;
    w.exec = 1'($urandom_range(0, 1));
    w.wr = 1'($urandom_range(0, 1));
    w.address = $urandom;
    return w;
  endfunction

  function automatic seg_req_t seg_write(logic [IDX_W-1:0] k, logic ld,
                                         logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] msz,
                                         logic [ADDR_W-1:0] fsz, logic [ADDR_W-1:0] foff,
                                         logic ex, logic wr);
    seg_req_t w;
    w = noise_word();
    w.op = OP_WRITE;
    w.idx = k;
    w.loadable = ld;
    w.base = base;
    w.mem_size = msz;
    w.file_size = fsz;
    w.file_offset = foff;
    w.exec = ex;
    w.wr = wr;
    return w;
  endfunction

  function automatic seg_req_t seg_lookup(logic [ADDR_W-1:0] addr);
    seg_req_t w;
    w = noise_word();
    w.op = OP_LOOKUP;
    w.address = addr;
    return w;
  endfunction

  function automatic seg_req_t fill_entry(logic [IDX_W-1:0] k);
    seg_req_t w;
    w = noise_word();
    w.op = OP_WRITE;
    w.idx = k;
    w.loadable = ($urandom_range(0, 7) != 0);
    w.base = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 'h3000) : $urandom;
    w.mem_size = $urandom_range(1, 4096);
    w.file_size = w.mem_size;
    case ($urandom_range(0, 9))
      0: w.mem_size = '0;
      1: begin
        w.base = 32'hFFFF_F000 | $urandom_range(0, 'hFFF);
        w.mem_size = $urandom_range('h1000, 'h2000);
        w.file_size = w.mem_size;
      end
      2: begin
        w.mem_size = $urandom;
        w.file_size = w.mem_size;
      end
      3: w.file_size = w.mem_size ^ $urandom_range(1, 'hFFFF);
      4: w.file_offset = 32'hFFFF_FFFF - $urandom_range(0, 'hFFF);
      default: ;
    endcase
    return w;
  endfunction

  function automatic seg_req_t probe();
    seg_req_t          w;
    int                k;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] s;
    w = noise_word();
    w.op = OP_LOOKUP;
    if (span == 0 || $urandom_range(0, 9) == 0) return w;
    k = $urandom_range(0, span - 1);
    b = aim_base[k];
    s = aim_size[k];
    case ($urandom_range(0, 5))
      0: w.address = b;
      1: w.address = b + s - 1;
      2: w.address = b + s;
      3: w.address = b - 1;
      default: w.address = (s == 0) ? b : b + ($urandom % s);
    endcase
    return w;
  endfunction

  function automatic int first_gap();
    for (int i = 0; i < span; i++) begin
      if (!written[i]) return i;
    end
    return -1;
  endfunction

  task automatic drive(input seg_req_t w);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.op <= w.op;
    req_ch.entry_index <= w.idx;
    req_ch.entry_loadable <= w.loadable;
    req_ch.entry_base <= w.base;
    req_ch.entry_mem_size <= w.mem_size;
    req_ch.entry_file_size <= w.file_size;
    req_ch.entry_file_offset <= w.file_offset;
    req_ch.entry_exec <= w.exec;
    req_ch.entry_write <= w.wr;
    req_ch.address <= w.address;
    do @(posedge clk); while (!req_ch.ready);
    if (w.op == OP_WRITE) begin
      written[w.idx] = 1'b1;
      aim_base[w.idx] = w.base;
      aim_size[w.idx] = w.mem_size;
    end
  endtask

  task automatic pace();
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic set_count(logic [CNT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    span = (v > MAX_SEGMENTS) ? MAX_SEGMENTS : v;
  endtask

  task automatic random_items(int count);
    int gap;
    for (int n = 0; n < count; n++) begin
      pace();
      gap = first_gap();
      if (gap >= 0) begin
        drive(fill_entry(gap[IDX_W-1:0]));
      end else if ($urandom_range(0, 3) == 0) begin
        drive(fill_entry(IDX_W'($urandom_range(0, MAX_SEGMENTS - 1))));
      end else begin
        drive(probe());
      end
    end
  endtask

  initial begin
    int plan [8];
    plan = '{16, 31, 1, 17, 0, 8, 0, 16};
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_WRITE;
    req_ch.entry_index = '0;
    req_ch.entry_loadable = 1'b0;
    req_ch.entry_base = '0;
    req_ch.entry_mem_size = '0;
    req_ch.entry_file_size = '0;
    req_ch.entry_file_offset = '0;
    req_ch.entry_exec = 1'b0;
    req_ch.entry_write = 1'b0;
    req_ch.address = '0;
    written = '0;
    span = 0;
    gap_pct = 30;
    stall_pct = 5;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    drive(seg_lookup(32'h0000_1000));
    drive(seg_write(4'd0, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1));
    drive(seg_write(4'd1, 1'b1, 32'h1000, 32'h100, 32'h100, 32'hFFFF_FFFF, 1'b1, 1'b0));
    drive(seg_write(4'd2, 1'b1, 32'h1000, 32'h0, 32'h0, 32'h5, 1'b0, 1'b1));
    drive(seg_write(4'd3, 1'b1, 32'h2000, 32'h100, 32'h80, 32'h1234, 1'b1, 1'b1));
    drive(seg_write(4'd15, 1'b1, 32'hFFFF_FF00, 32'h200, 32'h200, 32'h0, 1'b0, 1'b0));
    set_count(CNT_W'(4));
    drive(seg_lookup(32'h0000_1000));
    drive(seg_lookup(32'h0000_10FF));
    drive(seg_lookup(32'h0000_1100));
    drive(seg_lookup(32'h0000_0FFF));
    drive(seg_lookup(32'h0000_2050));
    drive(seg_lookup(32'h0000_20FF));
    drive(seg_lookup(32'h0000_0000));
    drive(seg_lookup(32'hFFFF_FFFF));
    drive(seg_write(4'd4, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                    1'b1, 1'b1));
    set_count(CNT_W'(5));
    drive(seg_lookup(32'hFFFF_FFFE));
    drive(seg_lookup(32'hFFFF_FFFF));
    drive(seg_lookup(32'h0000_1050));
    drive(seg_lookup(32'h0000_2000));

    for (int p = 0; p < 8; p++) begin
      set_count(CNT_W'((p == 6) ? $urandom_range(0, 31) : plan[p]));
      calm = (p == 7);
      gap_pct = (p == 3) ? 0 : 30;
      stall_pct = (p == 4) ? 0 : 5;
      if (p == 2) begin
        random_items(55);
        drain();
        random_items(55);
      end else begin
        random_items(110);
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/sat_pkg.sv
src/sat_if.sv
src/sat_table.sv
src/sat_walker.sv
src/segment_address_translator.sv
tb/sv/segment_address_translator_checker.sv
tb/sv/segment_address_translator_tb.sv
